FILE: sv/sort_rank_and_band_defines.svh
// Assertion macros for the sort_rank_and_band block.
// Included by sort_rank_and_band.sv, the RTL file that carries concurrent checks; no other dependencies.
`ifndef SORT_RANK_AND_BAND_DEFINES_SVH
`define SORT_RANK_AND_BAND_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srb check failed");
// next-cycle implication
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srb check failed");
`else
`define SRB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/srb_pkg.sv
// Shared types and constants for sort_rank_and_band.
// No dependencies.
package srb_pkg;

    localparam int COUNT   = 64;
    localparam int CNT_W   = $clog2(COUNT + 1);
    localparam int SCORE_W = 7;
    localparam int RANK_W  = 7;
    localparam int BAND_W  = 3;
    localparam int LIM_W   = 8;
    localparam int IDX_W   = 2;

    localparam logic [BAND_W-1:0] BAND_A = 3'd0;
    localparam logic [BAND_W-1:0] BAND_B = 3'd1;
    localparam logic [BAND_W-1:0] BAND_C = 3'd2;
    localparam logic [BAND_W-1:0] BAND_D = 3'd3;
    localparam logic [BAND_W-1:0] BAND_F = 3'd4;

    localparam logic [IDX_W-1:0] REG_BAND_A = 2'd0;
    localparam logic [IDX_W-1:0] REG_BAND_B = 2'd1;
    localparam logic [IDX_W-1:0] REG_BAND_C = 2'd2;
    localparam logic [IDX_W-1:0] REG_BAND_D = 2'd3;

    localparam logic [LIM_W-1:0] RST_LIM_A = 8'd20;
    localparam logic [LIM_W-1:0] RST_LIM_B = 8'd35;
    localparam logic [LIM_W-1:0] RST_LIM_C = 8'd60;
    localparam logic [LIM_W-1:0] RST_LIM_D = 8'd90;

    typedef struct packed {
        logic load;   // insert the broadcast score
        logic shift;  // move every value one cell toward the head
    } t_cell_ctl;

    typedef struct packed {
        logic             emit;
        logic             first;
        logic             last;
        logic [CNT_W-1:0] pos;    // sorted position, counting from 1
    } t_emit_ctl;

    typedef struct packed {
        logic [LIM_W-1:0] a;
        logic [LIM_W-1:0] b;
        logic [LIM_W-1:0] c;
        logic [LIM_W-1:0] d;
    } t_limits;

endpackage

FILE: sv/srb_cell.sv
// One cell of the insertion chain: holds a single score.
// Depends on srb_pkg.
module srb_cell (
    input  logic                         i_clk,
    input  srb_pkg::t_cell_ctl           i_ctl,
    input  logic                         i_occ,
    input  logic [srb_pkg::SCORE_W-1:0]  i_score,
    input  logic [srb_pkg::SCORE_W-1:0]  i_prev_val,
    input  logic                         i_prev_keep,
    input  logic [srb_pkg::SCORE_W-1:0]  i_next_val,
    output logic [srb_pkg::SCORE_W-1:0]  o_val,
    output logic                         o_keep
);

    logic [srb_pkg::SCORE_W-1:0] r_val;
    logic [srb_pkg::SCORE_W-1:0] n_val;

    // equal scores stay ahead of the new one
    assign o_keep = i_occ && (r_val >= i_score);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.load) begin
            if (o_keep) begin
                n_val = r_val;
            end else if (i_prev_keep) begin
                n_val = i_score;
            end else begin
                n_val = i_prev_val;
            end
        end else if (i_ctl.shift) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

FILE: sv/srb_rank.sv
// Output stage: competition rank, band lookup and result registers.
// Depends on srb_pkg.
module srb_rank (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srb_pkg::t_emit_ctl           i_ctl,
    input  logic [srb_pkg::SCORE_W-1:0]  i_score,
    input  srb_pkg::t_limits             i_lim,
    output logic                         o_valid,
    output logic [srb_pkg::RANK_W-1:0]   o_rank_out,
    output logic [srb_pkg::SCORE_W-1:0]  o_score_out,
    output logic [srb_pkg::BAND_W-1:0]   o_band_out,
    output logic                         o_last_out
);

    logic [srb_pkg::CNT_W-1:0]   r_rank;
    logic [srb_pkg::CNT_W-1:0]   n_rank;
    logic [srb_pkg::SCORE_W-1:0] r_prev;
    logic [srb_pkg::LIM_W-1:0]   w_rank_ext;
    logic [srb_pkg::BAND_W-1:0]  w_band;
    logic                        r_valid;
    logic [srb_pkg::RANK_W-1:0]  r_rank_out;
    logic [srb_pkg::SCORE_W-1:0] r_score_out;
    logic [srb_pkg::BAND_W-1:0]  r_band_out;
    logic                        r_last_out;

    always_comb begin
        if (i_ctl.first) begin
            n_rank = srb_pkg::CNT_W'(1);
        end else if (i_score != r_prev) begin
            n_rank = i_ctl.pos;
        end else begin
            n_rank = r_rank;
        end
    end

    assign w_rank_ext = srb_pkg::LIM_W'(n_rank);

    always_comb begin
        if (w_rank_ext <= i_lim.a) begin
            w_band = srb_pkg::BAND_A;
        end else if (w_rank_ext <= i_lim.b) begin
            w_band = srb_pkg::BAND_B;
        end else if (w_rank_ext <= i_lim.c) begin
            w_band = srb_pkg::BAND_C;
        end else if (w_rank_ext <= i_lim.d) begin
            w_band = srb_pkg::BAND_D;
        end else begin
            w_band = srb_pkg::BAND_F;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_rank      <= n_rank;
            r_prev      <= i_score;
            r_rank_out  <= srb_pkg::RANK_W'(n_rank);
            r_score_out <= i_score;
            r_band_out  <= w_band;
            r_last_out  <= i_ctl.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_rank_out  = r_rank_out;
    assign o_score_out = r_score_out;
    assign o_band_out  = r_band_out;
    assign o_last_out  = r_last_out;

endmodule

FILE: sv/sort_rank_and_band.sv
// The chain takes the closing score as control enters ST_EMIT; the first result then leaves the srb_rank registers,
// and the results of a set follow on consecutive cycles.
// Throughput: one score per cycle while loading (insertion chain of COUNT cells);
// busy is high while the chain shifts the sorted set out.
// Reset (synchronous, active low) empties the set and restores the band limits.
// Results are strobed for one cycle each; the receiver cannot stall.
`include "sort_rank_and_band_defines.svh"
module sort_rank_and_band (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [srb_pkg::SCORE_W-1:0]  i_score_in,
    input  logic                         i_last_in,
    output logic                         o_valid,
    output logic [srb_pkg::RANK_W-1:0]   o_rank_out,
    output logic [srb_pkg::SCORE_W-1:0]  o_score_out,
    output logic [srb_pkg::BAND_W-1:0]   o_band_out,
    output logic                         o_last_out,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [srb_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [srb_pkg::LIM_W-1:0]    i_cfg_data
);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                      r_state;
    logic                      r_discard;
    logic [srb_pkg::CNT_W-1:0] r_count;
    logic [srb_pkg::CNT_W-1:0] r_idx;
    logic [srb_pkg::CNT_W-1:0] r_total;
    srb_pkg::t_limits          r_lim;

    logic                      w_accept;
    logic                      w_close;
    logic [srb_pkg::CNT_W-1:0] w_cnt1;
    logic                      w_emit_last;
    srb_pkg::t_cell_ctl        w_cell_ctl;
    srb_pkg::t_emit_ctl        w_emit_ctl;

    logic [srb_pkg::SCORE_W-1:0] w_val  [srb_pkg::COUNT];
    logic                        w_keep [srb_pkg::COUNT];
    logic [srb_pkg::COUNT-1:0]   w_occ;

    assign busy        = (r_state == ST_EMIT);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_cnt1      = r_count + srb_pkg::CNT_W'(1);
    assign w_close     = w_accept && !r_discard &&
                         (i_last_in || (w_cnt1 == srb_pkg::CNT_W'(srb_pkg::COUNT)));
    assign w_emit_last = (r_idx == r_total - srb_pkg::CNT_W'(1));

    assign w_cell_ctl.load  = w_accept && !r_discard;
    assign w_cell_ctl.shift = busy;

    assign w_emit_ctl.emit  = busy;
    assign w_emit_ctl.first = (r_idx == '0);
    assign w_emit_ctl.last  = w_emit_last;
    assign w_emit_ctl.pos   = r_idx + srb_pkg::CNT_W'(1);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_discard <= 1'b0;
            r_count   <= '0;
            r_idx     <= '0;
            r_total   <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (r_discard) begin
                            if (i_last_in) begin
                                r_discard <= 1'b0;
                            end
                        end else if (w_close) begin
                            r_state   <= ST_EMIT;
                            r_total   <= w_cnt1;
                            r_idx     <= '0;
                            r_count   <= '0;
                            r_discard <= !i_last_in;
                        end else begin
                            r_count <= w_cnt1;
                        end
                    end
                end
                ST_EMIT: begin
                    r_idx <= r_idx + srb_pkg::CNT_W'(1);
                    if (w_emit_last) begin
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // band limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.a <= srb_pkg::RST_LIM_A;
            r_lim.b <= srb_pkg::RST_LIM_B;
            r_lim.c <= srb_pkg::RST_LIM_C;
            r_lim.d <= srb_pkg::RST_LIM_D;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                srb_pkg::REG_BAND_A: r_lim.a <= i_cfg_data;
                srb_pkg::REG_BAND_B: r_lim.b <= i_cfg_data;
                srb_pkg::REG_BAND_C: r_lim.c <= i_cfg_data;
                srb_pkg::REG_BAND_D: r_lim.d <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // insertion chain, head at cell 0 holds the highest score
    for (genvar g = 0; g < srb_pkg::COUNT; g++) begin : g_cell
        logic [srb_pkg::SCORE_W-1:0] w_prev_val;
        logic                        w_prev_keep;
        logic [srb_pkg::SCORE_W-1:0] w_next_val;

        assign w_occ[g] = (srb_pkg::CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_prev_val  = '0;
            assign w_prev_keep = 1'b1;
        end else begin : g_body
            assign w_prev_val  = w_val[g-1];
            assign w_prev_keep = w_keep[g-1];
        end

        if (g == srb_pkg::COUNT - 1) begin : g_tail
            assign w_next_val = '0;
        end else begin : g_mid
            assign w_next_val = w_val[g+1];
        end

        srb_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_cell_ctl),
            .i_occ       (w_occ[g]),
            .i_score     (i_score_in),
            .i_prev_val  (w_prev_val),
            .i_prev_keep (w_prev_keep),
            .i_next_val  (w_next_val),
            .o_val       (w_val[g]),
            .o_keep      (w_keep[g])
        );
    end

    srb_rank u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_emit_ctl),
        .i_score     (w_val[0]),
        .i_lim       (r_lim),
        .o_valid     (o_valid),
        .o_rank_out  (o_rank_out),
        .o_score_out (o_score_out),
        .o_band_out  (o_band_out),
        .o_last_out  (o_last_out)
    );

    `SRB_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count < srb_pkg::CNT_W'(srb_pkg::COUNT))
    `SRB_ASSERT_NOW(a_idx_below_total, i_clk, i_rst_n, busy, r_idx < r_total)
    `SRB_ASSERT_NEXT(a_close_goes_busy, i_clk, i_rst_n, w_close, busy && r_idx == '0)
    `SRB_ASSERT_NEXT(a_emit_strobes, i_clk, i_rst_n, busy, o_valid && o_rank_out != '0)
    `SRB_ASSERT_NEXT(a_last_ends_set, i_clk, i_rst_n, busy && w_emit_last, o_last_out && !busy)

endmodule

FILE: verif/tb_sort_rank_and_band.sv
// Self-checking testbench for sort_rank_and_band: sorted, ranked and banded score sets.
// Holds its own insertion-sort predictor and compares every strobed result against it.
// Depends on srb_pkg and the sort_rank_and_band RTL.
module tb_sort_rank_and_band;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 12;

    typedef struct packed {
        logic [srb_pkg::SCORE_W-1:0] score;
        logic                        last;
    } t_score_item;

    typedef struct packed {
        logic [srb_pkg::RANK_W-1:0]  rank;
        logic [srb_pkg::SCORE_W-1:0] score;
        logic [srb_pkg::BAND_W-1:0]  band;
        logic                        last;
    } t_ranked;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [srb_pkg::SCORE_W-1:0]  i_score_in;
    logic                         i_last_in;
    logic                         o_valid;
    logic [srb_pkg::RANK_W-1:0]   o_rank_out;
    logic [srb_pkg::SCORE_W-1:0]  o_score_out;
    logic [srb_pkg::BAND_W-1:0]   o_band_out;
    logic                         o_last_out;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [srb_pkg::IDX_W-1:0]    i_cfg_index;
    logic [srb_pkg::LIM_W-1:0]    i_cfg_data;

    sort_rank_and_band dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_score_in  (i_score_in),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .o_rank_out  (o_rank_out),
        .o_score_out (o_score_out),
        .o_band_out  (o_band_out),
        .o_last_out  (o_last_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [srb_pkg::SCORE_W-1:0] chain [srb_pkg::COUNT];
    int                          fill_count;
    bit                          dropping;
    srb_pkg::t_limits            limits;

    t_score_item score_q [$];
    t_ranked     ranked_q [$];
    t_score_item presented;

    int fault_count;
    int cycle_count;
    int scores_accepted;
    int sets_closed;
    int results_checked;
    int cfg_writes;
    int burst_left;
    int gap_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [srb_pkg::BAND_W-1:0] band_of(int rank);
        if (rank <= limits.a) return srb_pkg::BAND_A;
        if (rank <= limits.b) return srb_pkg::BAND_B;
        if (rank <= limits.c) return srb_pkg::BAND_C;
        if (rank <= limits.d) return srb_pkg::BAND_D;
        return srb_pkg::BAND_F;
    endfunction

    // Insert one score into the sorted chain; on close, queue the ranked set.
    function automatic void insert_and_rank(logic [srb_pkg::SCORE_W-1:0] score, logic last);
        int n;
        int pos;
        int rank;
        t_ranked r;
        if (dropping) begin
            if (last) dropping = 1'b0;
            return;
        end
        n = fill_count;
        if (n >= srb_pkg::COUNT) n = 0;
        pos = n;
        while (pos > 0 && chain[pos-1] < score) begin
            chain[pos] = chain[pos-1];
            pos--;
        end
        chain[pos] = score;
        n++;
        if (!last && n < srb_pkg::COUNT) begin
            fill_count = n;
            return;
        end
        // closed by count: ignore everything up to the next last mark
        if (!last) dropping = 1'b1;
        fill_count = 0;
        sets_closed++;
        rank = 1;
        for (int k = 0; k < n; k++) begin
            if (k > 0 && chain[k] != chain[k-1]) rank = k + 1;
            r.rank  = srb_pkg::RANK_W'(rank);
            r.score = chain[k];
            r.band  = band_of(rank);
            r.last  = (k == n - 1);
            ranked_q.push_back(r);
        end
    endfunction

    function automatic logic [srb_pkg::SCORE_W-1:0] draw_score(int style, int base);
        case (style)
            0: return srb_pkg::SCORE_W'($urandom_range(0, 127));
            1: return srb_pkg::SCORE_W'(base + $urandom_range(0, 2));   // tie clusters
            default: begin
                case ($urandom_range(0, 3))
                    0: return srb_pkg::SCORE_W'(0);
                    1: return srb_pkg::SCORE_W'(1);
                    2: return srb_pkg::SCORE_W'(100);
                    default: return srb_pkg::SCORE_W'(127);
                endcase
            end
        endcase
    endfunction

    task automatic queue_set(int len, bit mark);
        int style;
        int base;
        t_score_item it;
        style = $urandom_range(0, 2);
        base  = $urandom_range(0, 125);
        for (int i = 0; i < len; i++) begin
            it.score = draw_score(style, base);
            it.last  = mark && (i == len - 1);
            score_q.push_back(it);
        end
        if (!mark) begin
            repeat ($urandom_range(0, 4)) begin
                it.score = srb_pkg::SCORE_W'($urandom);
                it.last  = 1'b0;
                score_q.push_back(it);
            end
            it.score = srb_pkg::SCORE_W'($urandom);
            it.last  = 1'b1;
            score_q.push_back(it);
        end
    endtask

    task automatic queue_list(input int vals [$]);
        t_score_item it;
        foreach (vals[i]) begin
            it.score = srb_pkg::SCORE_W'(vals[i]);
            it.last  = (i == vals.size() - 1);
            score_q.push_back(it);
        end
    endtask

    task automatic fill_phase(int budget, int full_kind);
        int used;
        int len;
        int r;
        used = 0;
        if (full_kind == 1) begin
            queue_set(srb_pkg::COUNT, 1'b0);
            used += srb_pkg::COUNT;
        end else if (full_kind == 2) begin
            queue_set(srb_pkg::COUNT, 1'b1);
            used += srb_pkg::COUNT;
        end
        while (used < budget) begin
            r = $urandom_range(0, 99);
            if (r < 55)      len = $urandom_range(1, 8);
            else if (r < 85) len = $urandom_range(9, 30);
            else if (r < 97) len = $urandom_range(31, srb_pkg::COUNT - 1);
            else             len = srb_pkg::COUNT;
            queue_set(len, (len < srb_pkg::COUNT) || ($urandom_range(0, 1) == 1));
            used += len;
        end
    endtask

    // wait for all requests sent and all results seen, then let the pipe settle
    task automatic drain();
        do @(posedge i_clk);
        while (score_q.size() != 0 || start || ranked_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes; caller lowers it
    task automatic write_reg(logic [srb_pkg::IDX_W-1:0] idx, logic [srb_pkg::LIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            srb_pkg::REG_BAND_A: limits.a = val;
            srb_pkg::REG_BAND_B: limits.b = val;
            srb_pkg::REG_BAND_C: limits.c = val;
            default:             limits.d = val;
        endcase
        cfg_writes++;
    endtask

    task automatic load_limits(logic [srb_pkg::LIM_W-1:0] a, logic [srb_pkg::LIM_W-1:0] b,
                               logic [srb_pkg::LIM_W-1:0] c, logic [srb_pkg::LIM_W-1:0] d);
        write_reg(srb_pkg::REG_BAND_A, a);
        write_reg(srb_pkg::REG_BAND_B, b);
        write_reg(srb_pkg::REG_BAND_C, c);
        write_reg(srb_pkg::REG_BAND_D, d);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [srb_pkg::LIM_W-1:0] draw_limit();
        if ($urandom_range(0, 3) == 0) return srb_pkg::LIM_W'($urandom_range(0, 255));
        return srb_pkg::LIM_W'($urandom_range(0, 70));
    endfunction

    // driver: one request per free slot, bursts separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                insert_and_rank(presented.score, presented.last);
                scores_accepted++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (score_q.size() > 0) begin
                    presented = score_q.pop_front();
                    start      <= 1'b1;
                    i_score_in <= presented.score;
                    i_last_in  <= presented.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        burst_left = 40;
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = $urandom_range(1, 6);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobed result must match the oldest expectation
    always @(posedge i_clk) begin
        t_ranked got;
        t_ranked want;
        if (i_rst_n && o_valid) begin
            got = '{o_rank_out, o_score_out, o_band_out, o_last_out};
            if (ranked_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: rank=%0d score=%0d band=%0d last=%0d",
                             got.rank, got.score, got.band, got.last);
            end else begin
                want = ranked_q.pop_front();
                results_checked++;
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"result %0d differs: expected rank=%0d score=%0d band=%0d ",
                                  "last=%0d, got rank=%0d score=%0d band=%0d last=%0d"},
                                 results_checked, want.rank, want.score, want.band,
                                 want.last, got.rank, got.score, got.band, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, ranked_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_score_in  = '0;
        i_last_in   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        fill_count  = 0;
        dropping    = 1'b0;
        limits      = '{a: srb_pkg::RST_LIM_A, b: srb_pkg::RST_LIM_B,
                        c: srb_pkg::RST_LIM_C, d: srb_pkg::RST_LIM_D};
        fault_count = 0;
        cycle_count = 0;
        scores_accepted = 0;
        sets_closed     = 0;
        results_checked = 0;
        cfg_writes      = 0;
        burst_left  = 0;
        gap_left    = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, scores above 100, ties, ascending input, one-score set
        queue_list('{0, 127, 100, 100, 50});
        queue_list('{127});
        queue_list('{0, 0, 0});
        queue_list('{1, 2, 3, 4});
        drain();
        load_limits(8'd1, 8'd2, 8'd3, 8'd4);
        queue_list('{9, 9, 8, 7, 6, 5, 5});
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: load_limits(srb_pkg::RST_LIM_A, srb_pkg::RST_LIM_B,
                               srb_pkg::RST_LIM_C, srb_pkg::RST_LIM_D);
                1: load_limits(8'd0, 8'd0, 8'd0, 8'd0);
                2: load_limits(8'd255, 8'd255, 8'd255, 8'd255);
                3: load_limits(8'd5, 8'd2, 8'd40, 8'd10);   // limits out of order
                4: load_limits(8'd1, 8'd2, 8'd3, 8'd4);
                default: load_limits(draw_limit(), draw_limit(), draw_limit(), draw_limit());
            endcase
            // pass 0 adds a full set without last mark, pass 3 a full set closed by its last mark
            fill_phase(35, (p == 0) ? 1 : (p == 3) ? 2 : 0);
            drain();
        end

        $display("covered %0d scores in %0d sets, %0d results checked, %0d register writes",
                 scores_accepted, sets_closed, results_checked, cfg_writes);
        if (ranked_q.size() != 0)
            $display("%0d expected results never arrived", ranked_q.size());
        if (fault_count == 0 && ranked_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", fault_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
